FILE: rtl/sbfl_pkg.sv
// ----------------------------------------------------------------------------
// Serial boot frame loader package
// Frame phase codes, frame byte values and the result record.
// ----------------------------------------------------------------------------
package sbfl_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned AddrBits = 32;

  localparam logic [ByteBits-1:0] SohByte = 8'h01;
  localparam logic [ByteBits-1:0] StxByte = 8'h02;
  localparam logic [ByteBits-1:0] EtxByte = 8'h03;

  typedef enum logic [7:0] {
    PhHeader = 8'b0000_0001,
    PhAddr0  = 8'b0000_0010,
    PhAddr1  = 8'b0000_0100,
    PhAddr2  = 8'b0000_1000,
    PhAddr3  = 8'b0001_0000,
    PhMarker = 8'b0010_0000,
    PhData   = 8'b0100_0000,
    PhDone   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic                write_enable;
    logic [AddrBits-1:0] write_address;
    logic [ByteBits-1:0] write_byte;
    logic                header_error;
    logic                marker_error;
    logic                load_done;
  } result_t;

endpackage

FILE: rtl/sbfl_frame_fsm.sv
// ----------------------------------------------------------------------------
// Serial boot frame loader frame tracker
// Holds the frame phase, the running address and the sticky error flags, and
// forms the result for one byte from the current state and that byte.
// ----------------------------------------------------------------------------
module sbfl_frame_fsm #(
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [sbfl_pkg::ByteBits-1:0]   rx_byte_i,
  output sbfl_pkg::result_t               result_o
);

  sbfl_pkg::phase_e         phase_q, phase_d;
  logic [ADDRESS_WIDTH-1:0] next_address_q, next_address_d;
  logic                     header_bad_q, header_bad_d;
  logic                     marker_bad_q, marker_bad_d;
  logic [4:0]               shift;
  logic [sbfl_pkg::AddrBits-1:0] addr_merged;
  logic                     write_enable;

  assign addr_merged = sbfl_pkg::AddrBits'(next_address_q)
                     | (sbfl_pkg::AddrBits'(rx_byte_i) << shift);

  always_comb begin
    phase_d        = phase_q;
    next_address_d = next_address_q;
    header_bad_d   = header_bad_q;
    marker_bad_d   = marker_bad_q;
    shift          = 5'd0;
    write_enable   = 1'b0;
    unique case (phase_q)
      sbfl_pkg::PhHeader: begin
        if (rx_byte_i != sbfl_pkg::SohByte) begin
          header_bad_d = 1'b1;
        end
        phase_d = sbfl_pkg::PhAddr0;
      end
      sbfl_pkg::PhAddr0: begin
        shift          = 5'd0;
        next_address_d = addr_merged[ADDRESS_WIDTH-1:0];
        phase_d        = sbfl_pkg::PhAddr1;
      end
      sbfl_pkg::PhAddr1: begin
        shift          = 5'd8;
        next_address_d = addr_merged[ADDRESS_WIDTH-1:0];
        phase_d        = sbfl_pkg::PhAddr2;
      end
      sbfl_pkg::PhAddr2: begin
        shift          = 5'd16;
        next_address_d = addr_merged[ADDRESS_WIDTH-1:0];
        phase_d        = sbfl_pkg::PhAddr3;
      end
      sbfl_pkg::PhAddr3: begin
        shift          = 5'd24;
        next_address_d = addr_merged[ADDRESS_WIDTH-1:0];
        phase_d        = sbfl_pkg::PhMarker;
      end
      sbfl_pkg::PhMarker: begin
        if (rx_byte_i != sbfl_pkg::StxByte) begin
          marker_bad_d = 1'b1;
        end
        phase_d = sbfl_pkg::PhData;
      end
      sbfl_pkg::PhData: begin
        if (rx_byte_i == sbfl_pkg::EtxByte) begin
          phase_d = sbfl_pkg::PhDone;
        end else begin
          write_enable   = 1'b1;
          next_address_d = next_address_q + ADDRESS_WIDTH'(1'b1);
        end
      end
      sbfl_pkg::PhDone: begin
        phase_d = sbfl_pkg::PhDone;
      end
      default: begin
        phase_d = sbfl_pkg::PhDone;
      end
    endcase
  end

  always_comb begin
    result_o.write_enable  = write_enable;
    result_o.write_address = write_enable ? sbfl_pkg::AddrBits'(next_address_q)
                                          : '0;
    result_o.write_byte    = write_enable ? rx_byte_i : '0;
    result_o.header_error  = header_bad_d;
    result_o.marker_error  = marker_bad_d;
    result_o.load_done     = (phase_d == sbfl_pkg::PhDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= sbfl_pkg::PhHeader;
      next_address_q <= '0;
      header_bad_q   <= 1'b0;
      marker_bad_q   <= 1'b0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      next_address_q <= next_address_d;
      header_bad_q   <= header_bad_d;
      marker_bad_q   <= marker_bad_d;
    end
  end

endmodule

FILE: rtl/serial_boot_frame_loader_top.sv
// ----------------------------------------------------------------------------
// Serial boot frame loader
// One request per cycle while in_stall_o is low; each result passes through the
// input register and then the result register. A stalled result holds the
// result register, and the input register too while it holds a request. Reset
// clears the frame phase, address, error flags and both register stages.
// ----------------------------------------------------------------------------
module serial_boot_frame_loader_top #(
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sbfl_pkg::ByteBits-1:0]     rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              write_enable_o,
  output logic [sbfl_pkg::AddrBits-1:0]     write_address_o,
  output logic [sbfl_pkg::ByteBits-1:0]     write_byte_o,
  output logic                              header_error_o,
  output logic                              marker_error_o,
  output logic                              load_done_o
);

  logic                          in_valid_q;
  logic [sbfl_pkg::ByteBits-1:0] rx_byte_q;
  logic                          out_valid_q;
  sbfl_pkg::result_t             result_q;
  sbfl_pkg::result_t             result_d;
  logic                          out_hold;
  logic                          step;

  assign out_hold   = out_valid_q & out_stall_i;
  assign in_stall_o = in_valid_q & out_hold;
  assign step       = in_valid_q & ~out_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      rx_byte_q  <= '0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
      if (in_valid_i) begin
        rx_byte_q <= rx_byte_i;
      end
    end
  end

  sbfl_frame_fsm #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_frame_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .rx_byte_i(rx_byte_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else if (!out_hold) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        result_q <= result_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = result_q.write_enable;
  assign write_address_o = result_q.write_address;
  assign write_byte_o    = result_q.write_byte;
  assign header_error_o  = result_q.header_error;
  assign marker_error_o  = result_q.marker_error;
  assign load_done_o     = result_q.load_done;

  a_no_write_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_enable_o |-> !load_done_o)
    else $error("write reported together with load done");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(load_done_o) |-> load_done_o)
    else $error("load done flag cleared");

  a_header_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(header_error_o) |-> header_error_o)
    else $error("header error flag cleared");

  a_stall_keeps_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q && $stable(rx_byte_q))
    else $error("input register changed while stalled");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Serial boot frame loader testbench
// Sends one complete boot frame through the loader: header, four address
// bytes, text marker, a long run of data bytes and ETX, then bytes after
// done. A clocked driver takes the bytes from a queue and sends them in
// bursts. A clocked monitor stalls the result side on changing patterns.
// Every result is checked, field by field, against a model of the frame
// parser. The base address is chosen so that the write address wraps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ByteBits = sbfl_pkg::ByteBits;
  localparam int unsigned AddrBits = sbfl_pkg::AddrBits;
  localparam int unsigned AddrW = 32;
  localparam logic [AddrBits-1:0] AddrMask = {AddrBits{1'b1}} >> (AddrBits - AddrW);
  localparam int unsigned RandomBytes = 1800;

  typedef struct {
    logic [ByteBits-1:0] data;
    bit                  drain_first;
  } rx_req_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  logic [ByteBits-1:0] rx_byte;
  logic                out_valid;
  logic                out_stall;
  logic                write_enable;
  logic [AddrBits-1:0] write_address;
  logic [ByteBits-1:0] write_byte;
  logic                header_error;
  logic                marker_error;
  logic                load_done;

  rx_req_t             rx_queue[$];
  sbfl_pkg::result_t   expected_results[$];
  int                  error_count = 0;

  sbfl_pkg::phase_e    model_phase;
  logic [AddrBits-1:0] model_addr;
  logic                model_header_bad;
  logic                model_marker_bad;

  int  burst_left;
  int  gap_left;
  bit  hold_req;
  int  stall_mode;
  int  stall_span;
  bit  stall_toggle;
  sbfl_pkg::result_t got_result;
  sbfl_pkg::result_t want_result;

  serial_boot_frame_loader_top #(
    .ADDRESS_WIDTH(AddrW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .write_enable_o (write_enable),
    .write_address_o(write_address),
    .write_byte_o   (write_byte),
    .header_error_o (header_error),
    .marker_error_o (marker_error),
    .load_done_o    (load_done)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic sbfl_pkg::result_t parse_frame_byte(logic [ByteBits-1:0] b);
    sbfl_pkg::result_t r;
    r = '0;
    case (model_phase)
      sbfl_pkg::PhHeader: begin
        if (b != sbfl_pkg::SohByte) model_header_bad = 1'b1;
        model_phase = sbfl_pkg::PhAddr0;
      end
      sbfl_pkg::PhAddr0: begin
        model_addr  = (model_addr | {24'h0, b}) & AddrMask;
        model_phase = sbfl_pkg::PhAddr1;
      end
      sbfl_pkg::PhAddr1: begin
        model_addr  = (model_addr | {16'h0, b, 8'h0}) & AddrMask;
        model_phase = sbfl_pkg::PhAddr2;
      end
      sbfl_pkg::PhAddr2: begin
        model_addr  = (model_addr | {8'h0, b, 16'h0}) & AddrMask;
        model_phase = sbfl_pkg::PhAddr3;
      end
      sbfl_pkg::PhAddr3: begin
        model_addr  = (model_addr | {b, 24'h0}) & AddrMask;
        model_phase = sbfl_pkg::PhMarker;
      end
      sbfl_pkg::PhMarker: begin
        if (b != sbfl_pkg::StxByte) model_marker_bad = 1'b1;
        model_phase = sbfl_pkg::PhData;
      end
      sbfl_pkg::PhData: begin
        if (b == sbfl_pkg::EtxByte) begin
          model_phase = sbfl_pkg::PhDone;
        end else begin
          r.write_enable  = 1'b1;
          r.write_address = model_addr & AddrMask;
          r.write_byte    = b;
          model_addr      = (model_addr + AddrBits'(1)) & AddrMask;
        end
      end
      default: ;
    endcase
    r.header_error = model_header_bad;
    r.marker_error = model_marker_bad;
    r.load_done    = (model_phase == sbfl_pkg::PhDone);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [AddrBits-1:0] got,
                                 logic [AddrBits-1:0] want);
    if (error_count < 100) begin
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  task automatic queue_byte(logic [ByteBits-1:0] b, bit drain);
    rx_req_t q;
    q.data        = b;
    q.drain_first = drain;
    rx_queue.push_back(q);
  endtask

  // Driver: sends requests from rx_queue in bursts separated by gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      rx_byte    <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      hold_req = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(parse_frame_byte(rx_byte));
        void'(rx_queue.pop_front());
      end
      if (!hold_req) begin
        if (rx_queue.size() == 0 || gap_left != 0 ||
            (rx_queue[0].drain_first && expected_results.size() != 0)) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          in_valid <= 1'b1;
          rx_byte  <= rx_queue[0].data;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Monitor: checks accepted results and drives the stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      stall_mode   <= 0;
      stall_span   <= 50;
      stall_toggle <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          want_result = expected_results.pop_front();
          got_result.write_enable  = write_enable;
          got_result.write_address = write_address;
          got_result.write_byte    = write_byte;
          got_result.header_error  = header_error;
          got_result.marker_error  = marker_error;
          got_result.load_done     = load_done;
          if (got_result.write_enable != want_result.write_enable)
            report_mismatch("write_enable", AddrBits'(got_result.write_enable),
                            AddrBits'(want_result.write_enable));
          if (got_result.write_address != want_result.write_address)
            report_mismatch("write_address", got_result.write_address,
                            want_result.write_address);
          if (got_result.write_byte != want_result.write_byte)
            report_mismatch("write_byte", AddrBits'(got_result.write_byte),
                            AddrBits'(want_result.write_byte));
          if (got_result.header_error != want_result.header_error)
            report_mismatch("header_error", AddrBits'(got_result.header_error),
                            AddrBits'(want_result.header_error));
          if (got_result.marker_error != want_result.marker_error)
            report_mismatch("marker_error", AddrBits'(got_result.marker_error),
                            AddrBits'(want_result.marker_error));
          if (got_result.load_done != want_result.load_done)
            report_mismatch("load_done", AddrBits'(got_result.load_done),
                            AddrBits'(want_result.load_done));
        end
      end
      if (stall_span <= 1) begin
        stall_mode <= $urandom_range(0, 3);
        stall_span <= $urandom_range(20, 200);
      end else begin
        stall_span <= stall_span - 1;
      end
      stall_toggle <= ~stall_toggle;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_toggle;
      endcase
    end
  end

  initial begin
    logic [AddrBits-1:0] base;
    logic [ByteBits-1:0] b;
    rst_ni           = 1'b0;
    model_phase      = sbfl_pkg::PhHeader;
    model_addr       = '0;
    model_header_bad = 1'b0;
    model_marker_bad = 1'b0;

    // The base sits close to the top so that the running address wraps.
    base = '0 - AddrBits'($urandom_range(1, 1500));
    queue_byte($urandom_range(0, 1) ? sbfl_pkg::SohByte
                                    : ByteBits'($urandom_range(2, 255)), 1'b0);
    queue_byte(base[7:0], 1'b0);
    queue_byte(base[15:8], 1'b0);
    queue_byte(base[23:16], 1'b0);
    queue_byte(base[31:24], 1'b0);
    queue_byte($urandom_range(0, 1) ? sbfl_pkg::StxByte : ~sbfl_pkg::StxByte, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(sbfl_pkg::SohByte, 1'b0);
    queue_byte(sbfl_pkg::StxByte, 1'b0);
    queue_byte(8'h04, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    for (int i = 0; i < RandomBytes; i++) begin
      b = ByteBits'($urandom_range(0, 255));
      while (b == sbfl_pkg::EtxByte) b = ByteBits'($urandom_range(0, 255));
      queue_byte(b, $urandom_range(0, 299) == 0);
    end
    queue_byte(sbfl_pkg::EtxByte, 1'b0);
    queue_byte(sbfl_pkg::EtxByte, 1'b1);
    queue_byte(sbfl_pkg::SohByte, 1'b0);
    queue_byte(sbfl_pkg::StxByte, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    for (int i = 0; i < 30; i++) queue_byte(ByteBits'($urandom_range(0, 255)), 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_queue.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("results missing", AddrBits'(expected_results.size()), '0);
    end
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
